// File: rtl/nfa_pkg.sv
`default_nettype none

package nfa_pkg;

    // Default sizes of the automaton.
    localparam int NUM_STATES_DEF  = 16;
    localparam int SYMBOL_BITS_DEF = 8;

    // Field widths of the item interface.
    localparam int STATE_IDX_W = 4;
    localparam int SYMBOL_W    = 8;
    localparam int MASK_W      = 16;
    localparam int MODE_W      = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 24;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_STATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_MASK    = 1'd1;

    // Item kinds carried in tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SYM
    } t_state;

endpackage

`default_nettype wire

// File: rtl/nfa_ram.sv
`default_nettype none

module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one read port with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/nfa_step.sv
`default_nettype none

module nfa_step #(
    parameter int NUM_STATES = 16
) (
    input  wire logic [NUM_STATES*NUM_STATES-1:0] i_row,
    input  wire logic [NUM_STATES-1:0]            i_active,
    input  wire logic [nfa_pkg::STATE_IDX_W-1:0]  i_src,
    input  wire logic [NUM_STATES-1:0]            i_mask,
    output logic      [NUM_STATES-1:0]            o_next,
    output logic      [NUM_STATES*NUM_STATES-1:0] o_row
);

    import nfa_pkg::*;

    // The row holds one next-state mask per source state for a single symbol.
    // The next set is the OR of the masks of all active states, and a table
    // load replaces the mask of one source state and keeps the others.
    always_comb begin
        o_next = '0;
        o_row  = i_row;
        for (int s = 0; s < NUM_STATES; s++) begin
            if (i_active[s]) begin
                o_next = o_next | i_row[s*NUM_STATES +: NUM_STATES];
            end
            if (32'(i_src) == s) begin
                o_row[s*NUM_STATES +: NUM_STATES] = i_mask;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/nfa_stream_matcher.sv
`default_nettype none

// Runs a nondeterministic automaton of NUM_STATES states over a symbol stream.
// The transition table lives in one memory with a row for each symbol, and
// each row holds the next-state masks of every source state. A start item
// is handled in the cycle in which it is accepted. A symbol item first reads
// the table row, then ORs together the masks of the active states. A load item
// reads the row, then writes it back with one mask replaced. The table memory
// has a registered read. After reset a clearing pass writes zeros to all
// 2**SYMBOL_BITS rows of the table (256 by default), and no
// item is accepted during it; configuration writes are taken at any time.
// A result waits in an output register, and the next item is accepted in
// the cycle in which that result is taken.
module nfa_stream_matcher #(
    parameter int NUM_STATES  = nfa_pkg::NUM_STATES_DEF,
    parameter int SYMBOL_BITS = nfa_pkg::SYMBOL_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input items.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: state_index[3:0], symbol[11:4], next_mask[27:12], zeros.
    input  wire logic [nfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0].
    input  wire logic [nfa_pkg::MODE_W-1:0]     s_axis_tuser,
    // Result items.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata from bit 0: accepted[0], active_set[16:1], dead[17], zeros.
    output logic      [nfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration writes.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [nfa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [nfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import nfa_pkg::*;

    localparam int ROW_W  = NUM_STATES * NUM_STATES;
    localparam int DEPTH  = 1 << SYMBOL_BITS;
    localparam int EXT_W  = (NUM_STATES > MASK_W) ? NUM_STATES : MASK_W;

    // Input fields.
    logic [STATE_IDX_W-1:0] in_src;
    logic [SYMBOL_W-1:0]    in_symbol;
    logic [MASK_W-1:0]      in_next_mask;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic [NUM_STATES-1:0]  in_mask;
    logic                   in_fire;
    logic                   out_free;

    assign in_src       = s_axis_tdata[STATE_IDX_W-1:0];
    assign in_symbol    = s_axis_tdata[STATE_IDX_W +: SYMBOL_W];
    assign in_next_mask = s_axis_tdata[STATE_IDX_W+SYMBOL_W +: MASK_W];
    assign in_sym       = in_symbol[SYMBOL_BITS-1:0];
    assign in_fire      = s_axis_tvalid && s_axis_tready;

    // Mask bits beyond the states are dropped.
    logic [EXT_W-1:0] in_mask_ext;
    assign in_mask_ext = EXT_W'(in_next_mask);
    assign in_mask     = in_mask_ext[NUM_STATES-1:0];

    // Registers.
    t_state                 r_state, n_state;
    logic [SYMBOL_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [STATE_IDX_W-1:0] r_init_state;
    logic [MASK_W-1:0]      r_final_mask;
    logic [NUM_STATES-1:0]  r_active, n_active;
    logic [STATE_IDX_W-1:0] r_src, n_src;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [NUM_STATES-1:0]  r_mask, n_mask;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_acc, n_out_acc;
    logic [MASK_W-1:0]      r_out_set, n_out_set;
    logic                   r_out_dead, n_out_dead;

    // The output register can take a new result when it is empty or being read.
    assign out_free     = !r_out_valid || m_axis_tready;

    // Table memory and step logic.
    logic                   mem_we;
    logic [SYMBOL_BITS-1:0] mem_waddr;
    logic [ROW_W-1:0]       mem_wdata;
    logic [ROW_W-1:0]       mem_rdata;
    logic [NUM_STATES-1:0]  step_next;
    logic [ROW_W-1:0]       step_row;

    nfa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (in_sym),
        .o_rdata (mem_rdata)
    );

    nfa_step #(
        .NUM_STATES (NUM_STATES)
    ) u_step (
        .i_row    (mem_rdata),
        .i_active (r_active),
        .i_src    (r_src),
        .i_mask   (r_mask),
        .o_next   (step_next),
        .o_row    (step_row)
    );

    // Initial set: the one-hot of initial_state, or empty when it is
    // beyond the states.
    logic [NUM_STATES-1:0] start_set;
    always_comb begin
        for (int s = 0; s < NUM_STATES; s++) begin
            start_set[s] = (32'(r_init_state) == s);
        end
    end

    // Controller: next state, memory access and result capture.
    logic                  out_load;
    logic [EXT_W-1:0]      active_ext;
    logic [EXT_W-1:0]      final_ext;

    assign final_ext = EXT_W'(r_final_mask);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_active      = r_active;
        n_src         = r_src;
        n_sym         = r_sym;
        n_mask        = r_mask;
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_sym;
        mem_wdata     = step_row;
        out_load      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SYMBOL_BITS'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = out_free;
                if (in_fire) begin
                    n_src  = in_src;
                    n_sym  = in_sym;
                    n_mask = in_mask;
                    case (s_axis_tuser)
                        MODE_LOAD: begin
                            if (32'(in_src) < NUM_STATES) begin
                                n_state = ST_LOAD;
                            end
                        end
                        MODE_START: begin
                            n_active = start_set;
                            out_load = 1'b1;
                        end
                        MODE_SYMBOL: begin
                            n_state = ST_SYM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                mem_we  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SYM: begin
                n_active = step_next;
                out_load = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result fields follow the new active set.
    assign active_ext  = EXT_W'(n_active);

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_acc   = r_out_acc;
        n_out_set   = r_out_set;
        n_out_dead  = r_out_dead;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_acc   = |(active_ext & final_ext);
            n_out_set   = active_ext[MASK_W-1:0];
            n_out_dead  = (n_active == '0);
        end
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
            r_init_state <= '0;
            r_final_mask <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_INITIAL_STATE: r_init_state <= i_cfg_data[STATE_IDX_W-1:0];
                    CFG_FINAL_MASK:    r_final_mask <= i_cfg_data[MASK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_sym      <= n_sym;
        r_mask     <= n_mask;
        r_out_acc  <= n_out_acc;
        r_out_set  <= n_out_set;
        r_out_dead <= n_out_dead;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - MASK_W - 2){1'b0}}, r_out_dead, r_out_set, r_out_acc};

endmodule

`default_nettype wire

// File: tb/sv/nfa_stream_matcher_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and configuration channels of the matcher, keeps its
// own copy of the transition table and the active set, and compares every
// result item taken from the block with the oldest outstanding prediction.
module nfa_stream_matcher_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [nfa_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [nfa_pkg::MODE_W-1:0]     i_s_tuser,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [nfa_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [nfa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [nfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import nfa_pkg::*;

    localparam int SYM_COUNT    = 1 << SYMBOL_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    // One result item as it leaves the block.
    typedef struct packed {
        logic              dead;
        logic [MASK_W-1:0] active_set;
        logic              accepted;
    } t_match_report;

    logic [MASK_W-1:0]      next_masks [NUM_STATES_DEF][SYM_COUNT];
    logic [MASK_W-1:0]      active_now;
    logic [STATE_IDX_W-1:0] start_state;
    logic [MASK_W-1:0]      accept_mask;
    t_match_report          reports_due [$];
    int                     fails;

    // The report that a start or symbol item gives for the new active set.
    function automatic t_match_report report_for(input logic [MASK_W-1:0] set);
        t_match_report rep;
        rep.accepted   = |(set & accept_mask);
        rep.active_set = set;
        rep.dead       = (set == '0);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        logic [STATE_IDX_W-1:0] src;
        logic [SYMBOL_W-1:0]    sym;
        logic [MASK_W-1:0]      mask;
        logic [MASK_W-1:0]      reach;
        t_match_report          got;
        t_match_report          want;

        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STATES_DEF; s++) begin
                for (int c = 0; c < SYM_COUNT; c++) begin
                    next_masks[s][c] = '0;
                end
            end
            active_now  = '0;
            start_state = '0;
            accept_mask = '0;
            reports_due.delete();
            fails       = 0;
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_INITIAL_STATE) begin
                    start_state = i_cfg_data[STATE_IDX_W-1:0];
                end else if (i_cfg_index == CFG_FINAL_MASK) begin
                    accept_mask = i_cfg_data[MASK_W-1:0];
                end
            end

            // Result items leaving the block, oldest prediction first.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[MASK_W+1:0];
                if (reports_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result: accepted=%0b set=%04h dead=%0b",
                                 $realtime, got.accepted, got.active_set, got.dead);
                    end
                end else begin
                    want = reports_due.pop_front();
                    if (got.accepted !== want.accepted || got.active_set !== want.active_set ||
                        got.dead !== want.dead) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: expected accepted=%0b set=%04h dead=%0b",
                                     $realtime, want.accepted, want.active_set, want.dead);
                            $display("%0t: actual   accepted=%0b set=%04h dead=%0b",
                                     $realtime, got.accepted, got.active_set, got.dead);
                        end
                    end
                end
            end

            // Items entering the block.
            if (i_s_tvalid && i_s_tready) begin
                src  = i_s_tdata[STATE_IDX_W-1:0];
                sym  = i_s_tdata[STATE_IDX_W +: SYMBOL_W];
                mask = i_s_tdata[STATE_IDX_W+SYMBOL_W +: MASK_W];
                case (i_s_tuser)
                    MODE_LOAD: begin
                        next_masks[src][sym] = mask;
                    end
                    MODE_START: begin
                        active_now = '0;
                        active_now[start_state] = 1'b1;
                        reports_due.push_back(report_for(active_now));
                    end
                    MODE_SYMBOL: begin
                        reach = '0;
                        for (int s = 0; s < NUM_STATES_DEF; s++) begin
                            if (active_now[s]) reach |= next_masks[s][sym];
                        end
                        active_now = reach;
                        reports_due.push_back(report_for(active_now));
                    end
                    default: begin
                        // The unused mode changes nothing.
                    end
                endcase
            end
        end

        o_fail_count <= fails;
        o_pending    <= reports_due.size();
    end

endmodule

// File: tb/sv/nfa_stream_matcher_tb.sv
`timescale 1ns / 1ps

// Drives items, register writes and back-pressure into the matcher and gives
// the verdict from the checker's failure count.
module nfa_stream_matcher_tb;

    import nfa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 1700;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int                     fail_count;
    int                     pending;
    int                     items_sent    = 0;
    int                     quiet_cycles  = 0;
    int                     stall_left    = 0;
    logic                   src_idle      = 1'b0;
    logic                   snk_idle      = 1'b0;
    int                     phase;
    int                     pick;
    logic [SYMBOL_W-1:0]    alphabet [4];

    nfa_stream_matcher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    nfa_stream_matcher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Table rows are mostly sparse so that the active set keeps a shape.
    function automatic logic [MASK_W-1:0] row_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return MASK_W'($urandom & $urandom & $urandom);
        if (r < 8) return MASK_W'($urandom);
        if (r == 8) return '0;
        return 16'h0001 << $urandom_range(0, 15);
    endfunction

    // Result side: ready drops for random stretches when stalling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (snk_idle) stall_left <= pick_gap();
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and waits until the block takes it.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [STATE_IDX_W-1:0] src,
                             input logic [SYMBOL_W-1:0] sym, input logic [MASK_W-1:0] mask);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0000, mask, sym, src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
        gap = src_idle ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every result has come back and any trailing load has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back.
    task automatic write_config(input logic [STATE_IDX_W-1:0] start_idx,
                                input logic [MASK_W-1:0] accept);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_INITIAL_STATE;
        i_cfg_data  <= CFG_DATA_W'(start_idx);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_FINAL_MASK;
        i_cfg_data  <= accept;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        src_idle = 1'b1;
        snk_idle <= 1'b1;

        // Directed part: highest initial state, every state accepting.
        write_config(4'd15, 16'hFFFF);
        send_item(MODE_START, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);     // empty table leaves nothing
        send_item(MODE_SYMBOL, 4'd15, 8'hAB, 16'hFFFF);    // an empty set stays empty
        send_item(MODE_LOAD, 4'd15, 8'hFF, 16'hFFFF);
        send_item(MODE_LOAD, 4'd0, 8'h00, 16'h0001);
        send_item(MODE_LOAD, 4'd15, 8'h00, 16'h8001);
        send_item(MODE_UNUSED, 4'd15, 8'hFF, 16'h0000);    // must not touch the table
        send_item(MODE_START, 4'd15, 8'hFF, 16'hFFFF);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'hFF, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'hFF, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h80, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_LOAD, 4'd15, 8'h00, 16'h0000);      // clear the mask of state 15 for symbol 00
        send_item(MODE_START, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);

        // Lowest initial state, nothing accepting.
        wait_idle();
        write_config(4'd0, 16'h0000);
        send_item(MODE_START, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_SYMBOL, 4'd0, 8'h00, 16'h0000);
        send_item(MODE_LOAD, 4'd0, 8'hFF, 16'hFFFF);
        send_item(MODE_SYMBOL, 4'd0, 8'hFF, 16'h0000);

        // Random part: per phase a fresh setting, a small alphabet, a batch of
        // table loads on it and then strings over it with some noise mixed in.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            wait_idle();
            src_idle = (phase % 4 == 0) || (phase % 4 == 2);
            snk_idle <= (phase % 4 == 0) || (phase % 4 == 3);
            case (phase)
                1: write_config(4'd0, 16'h0000);
                2: write_config(4'd15, 16'hFFFF);
                default: begin
                    pick = $urandom_range(0, 3);
                    write_config(STATE_IDX_W'($urandom_range(0, 15)),
                                 (pick == 0) ? 16'h0000 :
                                 (pick == 1) ? 16'hFFFF :
                                 (pick == 2) ? 16'(16'h0001 << $urandom_range(0, 15)) :
                                 16'($urandom));
                end
            endcase
            for (int a = 0; a < 4; a++) alphabet[a] = SYMBOL_W'($urandom_range(0, 255));
            if (phase % 3 == 0) begin
                alphabet[0] = 8'h00;
                alphabet[1] = 8'hFF;
            end
            repeat ($urandom_range(24, 40)) begin
                send_item(MODE_LOAD, STATE_IDX_W'($urandom_range(0, 15)),
                          alphabet[$urandom_range(0, 3)], row_mask());
            end
            repeat ($urandom_range(12, 20)) begin
                send_item(MODE_START, STATE_IDX_W'($urandom), SYMBOL_W'($urandom),
                          MASK_W'($urandom));
                repeat ($urandom_range(2, 14)) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0) begin
                        send_item(MODE_LOAD, STATE_IDX_W'($urandom), SYMBOL_W'($urandom),
                                  MASK_W'($urandom));
                    end else if (pick == 1) begin
                        send_item(MODE_UNUSED, STATE_IDX_W'($urandom), SYMBOL_W'($urandom),
                                  MASK_W'($urandom));
                    end else if (pick == 2) begin
                        send_item(MODE_SYMBOL, STATE_IDX_W'($urandom), SYMBOL_W'($urandom),
                                  MASK_W'($urandom));
                    end else begin
                        send_item(MODE_SYMBOL, STATE_IDX_W'($urandom),
                                  alphabet[$urandom_range(0, 3)], MASK_W'($urandom));
                    end
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/nfa_pkg.sv
rtl/nfa_ram.sv
rtl/nfa_step.sv
rtl/nfa_stream_matcher.sv
tb/sv/nfa_stream_matcher_checker.sv
tb/sv/nfa_stream_matcher_tb.sv
